>>> rtl/bpk_pkg.sv
// Shared types and constants for the msb-first bit packer.
// No dependencies; imported by bpk_front, bpk_back and msb_first_bit_packer.
package bpk_pkg;

	localparam int CODE_BITS  = 32;
	localparam int COUNT_BITS = 6;
	localparam int BYTE_BITS  = 8;

	localparam logic MODE_PACK  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// Work item handed from the front queue to the back end
	typedef struct packed {
		logic                  flush;
		logic [CODE_BITS-1:0]  code;
		logic [COUNT_BITS-1:0] count;
	} item_t;

endpackage

>>> rtl/bpk_front.sv
// Front end: accepts input beats, saturates the bit count, drops empty packs
// and queues work items for the back end. Depends on bpk_pkg.
module bpk_front #(
	parameter int CODE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          mode,
	input  logic [bpk_pkg::CODE_BITS-1:0] code,
	input  logic [bpk_pkg::COUNT_BITS-1:0] code_len,
	output logic                          head_valid,
	output bpk_pkg::item_t                head_item,
	input  logic                          head_pop
);
	import bpk_pkg::*;

	localparam int DEPTH = 2;
	localparam logic [COUNT_BITS:0] CodeWidthW = (COUNT_BITS+1)'(CODE_WIDTH);

	item_t             queue_q [DEPTH];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic [COUNT_BITS-1:0] sat_count;
	item_t             new_item;
	logic              drop;
	logic              push;
	logic              pop;

	always_comb begin
		if ({1'b0, code_len} > CodeWidthW) begin
			sat_count = CodeWidthW[COUNT_BITS-1:0];
		end else begin
			sat_count = code_len;
		end
		new_item.flush = (mode == MODE_FLUSH);
		new_item.code  = code;
		new_item.count = sat_count;
		// a pack of zero bits has no effect at all
		drop = !new_item.flush && (sat_count == '0);
	end

	assign item_ready = (cnt_q != 2'(DEPTH));
	assign push       = item_valid && item_ready && !drop;
	assign head_valid = (cnt_q != 2'd0);
	assign pop        = head_pop && head_valid;
	assign head_item  = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(DEPTH))
		else $error("queue count overflow");
	a_no_zero_pack: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (new_item.flush || new_item.count != '0))
		else $error("zero-length pack queued");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("queue count lost a pop");

endmodule

>>> rtl/bpk_back.sv
// Back end: holds the partial byte, consumes queued items one chunk per cycle
// unless the output stalls, drives the registered byte output. Uses bpk_pkg.
module bpk_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  bpk_pkg::item_t               head_item,
	output logic                         head_pop,
	output logic                         byte_valid,
	input  logic                         byte_ready,
	output logic [bpk_pkg::BYTE_BITS-1:0] out_byte,
	output logic                         last_byte
);
	import bpk_pkg::*;

	logic [BYTE_BITS-1:0]  partial_q;
	logic [2:0]            filled_q;
	logic                  cur_valid_q;
	logic                  cur_flush_q;
	logic [CODE_BITS-1:0]  cur_code_q;
	logic [COUNT_BITS-1:0] cur_rem_q;
	logic                  byte_valid_q;
	logic [BYTE_BITS-1:0]  out_byte_q;
	logic                  last_byte_q;

	logic [3:0]            room;
	logic [3:0]            take;
	logic [COUNT_BITS-1:0] rem_next;
	logic [BYTE_BITS-1:0]  mask;
	logic [BYTE_BITS-1:0]  chunk;
	logic [BYTE_BITS-1:0]  new_partial;
	logic [3:0]            fill_sum;
	logic                  emit;
	logic                  out_free;
	logic                  step_go;
	logic                  emit_go;
	logic                  done;
	logic                  load;

	always_comb begin
		room = 4'd8 - {1'b0, filled_q};
		if (cur_rem_q < {{(COUNT_BITS-4){1'b0}}, room}) begin
			take = cur_rem_q[3:0];
		end else begin
			take = room;
		end
		rem_next = cur_rem_q - COUNT_BITS'(take);
		mask     = 8'((9'd1 << take) - 9'd1);
		// code bits past the top of the word shift out as zero
		chunk       = 8'(cur_code_q >> rem_next) & mask;
		new_partial = partial_q | 8'(chunk << (room - take));
		fill_sum    = {1'b0, filled_q} + take;
		if (cur_flush_q) begin
			emit = (filled_q != 3'd0);
			done = 1'b1;
		end else begin
			emit = fill_sum[3];
			done = (rem_next == '0);
		end
	end

	assign out_free = !byte_valid_q || byte_ready;
	assign step_go  = cur_valid_q && (!emit || out_free);
	assign emit_go  = step_go && emit;
	assign load     = !cur_valid_q || (step_go && done);
	assign head_pop = load && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= '0;
			filled_q     <= '0;
			cur_valid_q  <= 1'b0;
			byte_valid_q <= 1'b0;
		end else begin
			if (step_go) begin
				if (cur_flush_q || fill_sum[3]) begin
					partial_q <= '0;
					filled_q  <= '0;
				end else begin
					partial_q <= new_partial;
					filled_q  <= fill_sum[2:0];
				end
			end
			if (load) begin
				cur_valid_q <= head_valid;
			end
			if (emit_go) begin
				byte_valid_q <= 1'b1;
			end else if (byte_ready) begin
				byte_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			cur_flush_q <= head_item.flush;
			cur_code_q  <= head_item.code;
			cur_rem_q   <= head_item.count;
		end else if (step_go && !cur_flush_q) begin
			cur_rem_q <= rem_next;
		end
		if (emit_go) begin
			out_byte_q  <= cur_flush_q ? partial_q : new_partial;
			// more bytes follow only if a full byte of code is still pending
			last_byte_q <= cur_flush_q || (rem_next < COUNT_BITS'(BYTE_BITS));
		end
	end

	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign last_byte  = last_byte_q;

	a_pack_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_valid_q && !cur_flush_q) |-> cur_rem_q != '0)
		else $error("live pack item with no bits left");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && cur_flush_q) |=> (byte_valid_q && last_byte_q))
		else $error("flush beat not marked last");
	a_mid_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && !cur_flush_q && rem_next >= COUNT_BITS'(BYTE_BITS))
		|=> (byte_valid_q && !last_byte_q))
		else $error("intermediate beat marked last");
	a_quiet_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step_go && !emit) |-> done)
		else $error("pack step left bits without filling a byte");

endmodule

>>> rtl/msb_first_bit_packer.sv
// MSB-first variable-length bit packer: 1..32-bit codes in, bytes out.
// An input beat is registered in the front queue, then as the back end's
// current item, and its first byte in the output register. The back end
// does one chunk per cycle unless byte_ready stalls it.
// Reset (arst_n, async): partial byte and bit count cleared, queue emptied.
// Depends on bpk_pkg, bpk_front, bpk_back.
module msb_first_bit_packer #(
	parameter int CODE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic                          mode,
	input  logic [bpk_pkg::CODE_BITS-1:0] code,
	input  logic [bpk_pkg::COUNT_BITS-1:0] code_len,
	output logic                          byte_valid,
	input  logic                          byte_ready,
	output logic [bpk_pkg::BYTE_BITS-1:0] out_byte,
	output logic                          last_byte
);
	import bpk_pkg::*;

	logic  head_valid;
	item_t head_item;
	logic  head_pop;

	bpk_front #(
		.CODE_WIDTH(CODE_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.code       (code),
		.code_len   (code_len),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_pop   (head_pop)
	);

	bpk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_pop   (head_pop),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule
